// File: sv/ipv4rl_pkg.sv
package ipv4rl_pkg;

  // Sizing defaults
  localparam int ROUTE_ENTRIES_DEF = 16;
  localparam int NUM_IFACES_DEF    = 4;
  localparam int CFG_REGS          = 4;
  localparam int CFG_ADDR_W        = 4;
  localparam int CFG_DATA_W        = 32;
  localparam int ENTRY_IDX_W       = 4;
  localparam int QUEUE_DEPTH       = 2;

  // Header field codes
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] TTL_EXPIRE = 8'd1;

  // ICMP answer codes
  localparam logic [7:0] ICMP_TYPE_TIMEX   = 8'd11;
  localparam logic [7:0] ICMP_TYPE_ECHO_RP = 8'd0;
  localparam logic [7:0] ICMP_TYPE_UNREACH = 8'd3;
  localparam logic [7:0] ICMP_CODE_PORT    = 8'd3;
  localparam logic [7:0] ICMP_CODE_NONE    = 8'd0;

  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_FWD    = 3'd1,
    ACT_TIMEX  = 3'd2,
    ACT_ECHO   = 3'd3,
    ACT_PORTUN = 3'd4,
    ACT_DROP   = 3'd5
  } action_t;

  typedef logic [31:0] ip_addr_t;
  typedef logic [CFG_REGS-1:0][CFG_DATA_W-1:0] iface_tab_t;

  typedef struct packed {
    ip_addr_t    dest;
    ip_addr_t    mask;
    ip_addr_t    gateway;
    logic [1:0]  port;
  } route_ent_t;

  // One classified word waiting between front and back
  typedef struct packed {
    action_t                 act;
    ip_addr_t                addr;
    logic [7:0]              ttl;
    logic [ENTRY_IDX_W-1:0]  wr_idx;
    logic                    wr_valid;
    route_ent_t              ent;
  } q_item_t;

  typedef struct packed {
    action_t     action;
    ip_addr_t    hop_addr;
    logic [1:0]  out_iface;
    logic [7:0]  ttl_out;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    ip_addr_t    reply_src_ip;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

endpackage

// File: sv/ipv4rl_cfg.sv
module ipv4rl_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipv4rl_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ipv4rl_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ipv4rl_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready,
  output ipv4rl_pkg::iface_tab_t              iface_ip
);

  ipv4rl_pkg::iface_tab_t iface_r;
  logic [1:0]             reg_idx;
  logic                   wr_en;

  // Decode the word address
  assign reg_idx = paddr[ipv4rl_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = iface_r[reg_idx];
  assign iface_ip = iface_r;

  // Store interface addresses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_r <= '0;
    end else if (wr_en) begin
      iface_r[reg_idx] <= pwdata;
    end
  end

endmodule

// File: sv/ipv4rl_front.sv
module ipv4rl_front #(
  parameter int NUM_IFACES = ipv4rl_pkg::NUM_IFACES_DEF
) (
  input  logic                                  in_req_type,
  input  logic [ipv4rl_pkg::ENTRY_IDX_W-1:0]    in_entry_index,
  input  logic                                  in_entry_valid,
  input  logic [31:0]                           in_entry_dest,
  input  logic [31:0]                           in_entry_mask,
  input  logic [31:0]                           in_entry_gateway,
  input  logic [1:0]                            in_entry_iface,
  input  logic [31:0]                           in_dst_ip,
  input  logic [31:0]                           in_src_ip,
  input  logic [7:0]                            in_ttl_in,
  input  logic [7:0]                            in_protocol,
  input  logic                                  in_echo_request_ok,
  input  ipv4rl_pkg::iface_tab_t                iface_ip,
  output ipv4rl_pkg::q_item_t                   item
);

  logic to_router;

  // Match destination against the active router interfaces
  always_comb begin
    to_router = 1'b0;
    for (int k = 0; k < ipv4rl_pkg::CFG_REGS; k++) begin
      if (k < NUM_IFACES && iface_ip[k] == in_dst_ip) begin
        to_router = 1'b1;
      end
    end
  end

  // Classify the word and pick the address to route on
  always_comb begin
    item              = '0;
    item.wr_idx       = in_entry_index;
    item.wr_valid     = in_entry_valid;
    item.ent.dest     = in_entry_dest;
    item.ent.mask     = in_entry_mask;
    item.ent.gateway  = in_entry_gateway;
    item.ent.port     = in_entry_iface;
    item.addr         = in_src_ip;
    item.ttl          = '0;
    priority if (in_req_type) begin
      item.act = ipv4rl_pkg::ACT_WRITE;
    end else if (!to_router) begin
      if (in_ttl_in <= ipv4rl_pkg::TTL_EXPIRE) begin
        item.act = ipv4rl_pkg::ACT_TIMEX;
      end else begin
        item.act  = ipv4rl_pkg::ACT_FWD;
        item.addr = in_dst_ip;
        item.ttl  = in_ttl_in - 8'd1;
      end
    end else if (in_protocol == ipv4rl_pkg::PROTO_ICMP) begin
      item.act = in_echo_request_ok ? ipv4rl_pkg::ACT_ECHO : ipv4rl_pkg::ACT_DROP;
    end else if (in_protocol == ipv4rl_pkg::PROTO_TCP ||
                 in_protocol == ipv4rl_pkg::PROTO_UDP) begin
      item.act = ipv4rl_pkg::ACT_PORTUN;
    end else begin
      item.act = ipv4rl_pkg::ACT_DROP;
    end
  end

endmodule

// File: sv/ipv4rl_fifo.sv
module ipv4rl_fifo #(
  parameter int DEPTH = ipv4rl_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ipv4rl_pkg::q_item_t  push_item,
  input  logic                 pop,
  output ipv4rl_pkg::q_item_t  head,
  output ipv4rl_pkg::q_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ipv4rl_pkg::q_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

endmodule

// File: sv/ipv4rl_back.sv
module ipv4rl_back #(
  parameter int ROUTE_ENTRIES = ipv4rl_pkg::ROUTE_ENTRIES_DEF,
  parameter int NUM_IFACES    = ipv4rl_pkg::NUM_IFACES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ipv4rl_pkg::q_item_t     head,
  input  ipv4rl_pkg::q_stat_t     q_stat,
  output logic                    pop,
  input  ipv4rl_pkg::iface_tab_t  iface_ip,
  input  logic                    out_ready,
  output logic                    out_valid,
  output ipv4rl_pkg::result_t     out_res
);

  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

  ipv4rl_pkg::back_state_t state_r, state_nxt;
  ipv4rl_pkg::q_item_t     cur_r, cur_nxt;
  logic [CNT_W-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]        chk_idx_r, chk_idx_nxt;
  logic                    best_found_r, best_found_nxt;
  logic [31:0]             best_mask_r, best_mask_nxt;
  logic [31:0]             best_gw_r, best_gw_nxt;
  logic [1:0]              best_port_r, best_port_nxt;
  ipv4rl_pkg::result_t     res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ipv4rl_pkg::result_t     out_res_r, out_res_nxt;
  logic [ROUTE_ENTRIES-1:0] valid_r;

  ipv4rl_pkg::route_ent_t  tab_mem [ROUTE_ENTRIES];
  ipv4rl_pkg::route_ent_t  rd_data_r;

  logic                    rd_en, wr_en, wr_ok, out_load, out_free, hit, scan_end;
  logic [IDX_W-1:0]        rd_addr, wr_addr;
  ipv4rl_pkg::result_t     route_res;

  assign out_free = !out_valid_r || out_ready;
  assign wr_ok    = int'(head.wr_idx) < ROUTE_ENTRIES;
  assign wr_addr  = IDX_W'(head.wr_idx);
  assign rd_addr  = scan_cnt_r[IDX_W-1:0];
  assign scan_end = (scan_cnt_r == CNT_W'(ROUTE_ENTRIES));

  // Compare the entry read last cycle; later entries win a tie
  assign hit = chk_vld_r && valid_r[chk_idx_r]
            && ((cur_r.addr & rd_data_r.mask) == rd_data_r.dest)
            && (rd_data_r.mask >= best_mask_r);

  // Build the answer from the winning route
  always_comb begin
    route_res = '0;
    route_res.action = ipv4rl_pkg::ACT_DROP;
    if (best_found_r && int'(best_port_r) < NUM_IFACES) begin
      route_res.action       = cur_r.act;
      route_res.hop_addr     = (best_gw_r != '0) ? best_gw_r : cur_r.addr;
      route_res.out_iface    = best_port_r;
      route_res.reply_src_ip = iface_ip[best_port_r];
      unique case (cur_r.act)
        ipv4rl_pkg::ACT_FWD: begin
          route_res.ttl_out      = cur_r.ttl;
          route_res.reply_src_ip = '0;
        end
        ipv4rl_pkg::ACT_TIMEX: begin
          route_res.msg_type = ipv4rl_pkg::ICMP_TYPE_TIMEX;
          route_res.msg_code = ipv4rl_pkg::ICMP_CODE_NONE;
        end
        ipv4rl_pkg::ACT_ECHO: begin
          route_res.msg_type = ipv4rl_pkg::ICMP_TYPE_ECHO_RP;
          route_res.msg_code = ipv4rl_pkg::ICMP_CODE_NONE;
        end
        ipv4rl_pkg::ACT_PORTUN: begin
          route_res.msg_type = ipv4rl_pkg::ICMP_TYPE_UNREACH;
          route_res.msg_code = ipv4rl_pkg::ICMP_CODE_PORT;
        end
        default: begin
          route_res = '0;
          route_res.action = ipv4rl_pkg::ACT_DROP;
        end
      endcase
    end
  end

  // Sequence one word at a time: write, drop, or scan the table
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    scan_cnt_nxt   = scan_cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    best_found_nxt = best_found_r;
    best_mask_nxt  = best_mask_r;
    best_gw_nxt    = best_gw_r;
    best_port_nxt  = best_port_r;
    res_nxt        = res_r;
    pop            = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      ipv4rl_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          priority if (head.act == ipv4rl_pkg::ACT_WRITE) begin
            wr_en          = wr_ok;
            res_nxt        = '0;
            res_nxt.action = ipv4rl_pkg::ACT_WRITE;
            state_nxt      = ipv4rl_pkg::ST_EMIT;
          end else if (head.act == ipv4rl_pkg::ACT_DROP) begin
            res_nxt        = '0;
            res_nxt.action = ipv4rl_pkg::ACT_DROP;
            state_nxt      = ipv4rl_pkg::ST_EMIT;
          end else begin
            cur_nxt        = head;
            scan_cnt_nxt   = '0;
            best_found_nxt = 1'b0;
            best_mask_nxt  = '0;
            state_nxt      = ipv4rl_pkg::ST_SCAN;
          end
        end
      end
      ipv4rl_pkg::ST_SCAN: begin
        if (!scan_end) begin
          rd_en        = 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end else if (!chk_vld_r) begin
          res_nxt   = route_res;
          state_nxt = ipv4rl_pkg::ST_EMIT;
        end
        if (hit) begin
          best_found_nxt = 1'b1;
          best_mask_nxt  = rd_data_r.mask;
          best_gw_nxt    = rd_data_r.gateway;
          best_port_nxt  = rd_data_r.port;
        end
      end
      ipv4rl_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ipv4rl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ipv4rl_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipv4rl_pkg::ST_IDLE;
      chk_vld_r   <= 1'b0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= head.wr_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    chk_idx_r    <= chk_idx_nxt;
    best_found_r <= best_found_nxt;
    best_mask_r  <= best_mask_nxt;
    best_gw_r    <= best_gw_nxt;
    best_port_r  <= best_port_nxt;
    res_r        <= res_nxt;
    out_res_r    <= out_res_nxt;
  end

  // Route table memory: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab_mem[wr_addr] <= head.ent;
    end
    if (rd_en) begin
      rd_data_r <= tab_mem[rd_addr];
    end
  end

  a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> state_r == ipv4rl_pkg::ST_SCAN)
    else $error("table compare outside of a scan");

  a_scan_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ipv4rl_pkg::ST_SCAN && scan_end && !chk_vld_r)
      |=> state_r == ipv4rl_pkg::ST_EMIT)
    else $error("scan did not finish after the last entry");

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.action == ipv4rl_pkg::ACT_DROP)
      |-> (out_res_r.hop_addr == '0 && out_res_r.reply_src_ip == '0 &&
           out_res_r.ttl_out == '0))
    else $error("drop result carries route fields");

endmodule

// File: sv/ipv4_route_lookup_forward_decision.sv
// IPv4 forwarding decision with a longest-prefix-match route table. A word
// on the input channel either writes one route slot (req_type 1) or looks up
// a packet header (req_type 0); every word gets exactly one result word, in
// order. Interface addresses are set over the APB port at 4*i. The front
// classifies each word at once and parks it in a two-word queue; the back
// takes one word at a time. A slot write or an early drop goes straight to
// the emit state in the back; a lookup scans the route memory one entry per
// cycle, and that scan sets the rate. The table's valid bits clear at reset;
// no clearing pass is needed.
module ipv4_route_lookup_forward_decision #(
  parameter int ROUTE_ENTRIES = ipv4rl_pkg::ROUTE_ENTRIES_DEF,
  parameter int NUM_IFACES    = ipv4rl_pkg::NUM_IFACES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [ipv4rl_pkg::ENTRY_IDX_W-1:0]  in_entry_index,
  input  logic                                in_entry_valid,
  input  logic [31:0]                         in_entry_dest,
  input  logic [31:0]                         in_entry_mask,
  input  logic [31:0]                         in_entry_gateway,
  input  logic [1:0]                          in_entry_iface,
  input  logic [31:0]                         in_dst_ip,
  input  logic [31:0]                         in_src_ip,
  input  logic [7:0]                          in_ttl_in,
  input  logic [7:0]                          in_protocol,
  input  logic                                in_echo_request_ok,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_action,
  output logic [31:0]                         out_hop_addr,
  output logic [1:0]                          out_out_iface,
  output logic [7:0]                          out_ttl_out,
  output logic [7:0]                          out_msg_type,
  output logic [7:0]                          out_msg_code,
  output logic [31:0]                         out_reply_src_ip,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipv4rl_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ipv4rl_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ipv4rl_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready
);

  ipv4rl_pkg::iface_tab_t iface_ip;
  ipv4rl_pkg::q_item_t    front_item;
  ipv4rl_pkg::q_item_t    q_head;
  ipv4rl_pkg::q_stat_t    q_stat;
  ipv4rl_pkg::result_t    res;
  logic                   q_push, q_pop;

  ipv4rl_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .iface_ip (iface_ip)
  );

  ipv4rl_front #(
    .NUM_IFACES (NUM_IFACES)
  ) u_front (
    .in_req_type        (in_req_type),
    .in_entry_index     (in_entry_index),
    .in_entry_valid     (in_entry_valid),
    .in_entry_dest      (in_entry_dest),
    .in_entry_mask      (in_entry_mask),
    .in_entry_gateway   (in_entry_gateway),
    .in_entry_iface     (in_entry_iface),
    .in_dst_ip          (in_dst_ip),
    .in_src_ip          (in_src_ip),
    .in_ttl_in          (in_ttl_in),
    .in_protocol        (in_protocol),
    .in_echo_request_ok (in_echo_request_ok),
    .iface_ip           (iface_ip),
    .item               (front_item)
  );

  // Accept a word whenever the queue has room
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  ipv4rl_fifo #(
    .DEPTH (ipv4rl_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  ipv4rl_back #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES),
    .NUM_IFACES    (NUM_IFACES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .iface_ip  (iface_ip),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_action       = res.action;
  assign out_hop_addr     = res.hop_addr;
  assign out_out_iface    = res.out_iface;
  assign out_ttl_out      = res.ttl_out;
  assign out_msg_type     = res.msg_type;
  assign out_msg_code     = res.msg_code;
  assign out_reply_src_ip = res.reply_src_ip;

endmodule

// File: tb/sv/route_decision_checker.sv
`timescale 1ns / 1ps

// Watch the word channels and the APB port, predict each forwarding decision
// and compare it with what comes out of the block.
module route_decision_checker #(
  parameter int ROUTE_ENTRIES = ipv4rl_pkg::ROUTE_ENTRIES_DEF,
  parameter int NUM_IFACES    = ipv4rl_pkg::NUM_IFACES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [ipv4rl_pkg::ENTRY_IDX_W-1:0]  in_entry_index,
  input  logic                                in_entry_valid,
  input  logic [31:0]                         in_entry_dest,
  input  logic [31:0]                         in_entry_mask,
  input  logic [31:0]                         in_entry_gateway,
  input  logic [1:0]                          in_entry_iface,
  input  logic [31:0]                         in_dst_ip,
  input  logic [31:0]                         in_src_ip,
  input  logic [7:0]                          in_ttl_in,
  input  logic [7:0]                          in_protocol,
  input  logic                                in_echo_request_ok,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [2:0]                          out_action,
  input  logic [31:0]                         out_hop_addr,
  input  logic [1:0]                          out_out_iface,
  input  logic [7:0]                          out_ttl_out,
  input  logic [7:0]                          out_msg_type,
  input  logic [7:0]                          out_msg_code,
  input  logic [31:0]                         out_reply_src_ip,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipv4rl_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ipv4rl_pkg::CFG_DATA_W-1:0]   pwdata,
  input  logic                                pready,
  output int                                  fails,
  output int                                  pending
);

  localparam int MAX_REPORTED = 10;

  // Shadow route table and interface addresses
  logic                 rt_valid [ROUTE_ENTRIES];
  ipv4rl_pkg::ip_addr_t rt_dest  [ROUTE_ENTRIES];
  ipv4rl_pkg::ip_addr_t rt_mask  [ROUTE_ENTRIES];
  ipv4rl_pkg::ip_addr_t rt_gw    [ROUTE_ENTRIES];
  logic [1:0]           rt_port  [ROUTE_ENTRIES];
  ipv4rl_pkg::ip_addr_t iface_addr [ipv4rl_pkg::CFG_REGS];

  ipv4rl_pkg::result_t decisions_due [$];
  int                  mismatches;

  // Longest mask wins; a later slot wins a tie
  function automatic int longest_match(input ipv4rl_pkg::ip_addr_t addr);
    int                   best;
    ipv4rl_pkg::ip_addr_t best_mask;
    best = -1;
    best_mask = '0;
    for (int i = 0; i < ROUTE_ENTRIES; i++) begin
      if (rt_valid[i] && ((addr & rt_mask[i]) == rt_dest[i]) && rt_mask[i] >= best_mask) begin
        best = i;
        best_mask = rt_mask[i];
      end
    end
    return best;
  endfunction

  function automatic bit is_router(input ipv4rl_pkg::ip_addr_t addr);
    for (int k = 0; k < NUM_IFACES && k < ipv4rl_pkg::CFG_REGS; k++)
      if (iface_addr[k] == addr) return 1'b1;
    return 1'b0;
  endfunction

  // Fill the route fields; action stays drop when there is no usable route
  function automatic ipv4rl_pkg::result_t route_toward(input ipv4rl_pkg::ip_addr_t addr);
    ipv4rl_pkg::result_t r;
    int                  hit;
    r = '0;
    r.action = ipv4rl_pkg::ACT_DROP;
    hit = longest_match(addr);
    if (hit >= 0 && int'(rt_port[hit]) < NUM_IFACES) begin
      r.action = ipv4rl_pkg::ACT_FWD;
      r.hop_addr = (rt_gw[hit] != '0) ? rt_gw[hit] : addr;
      r.out_iface = rt_port[hit];
      r.reply_src_ip = iface_addr[rt_port[hit]];
    end
    return r;
  endfunction

  function automatic ipv4rl_pkg::result_t forward_decision(
      input ipv4rl_pkg::ip_addr_t dst, input ipv4rl_pkg::ip_addr_t src,
      input logic [7:0] ttl, input logic [7:0] proto, input logic echo_ok);
    ipv4rl_pkg::result_t res, via;
    res = '0;
    res.action = ipv4rl_pkg::ACT_DROP;
    if (!is_router(dst)) begin
      if (ttl <= ipv4rl_pkg::TTL_EXPIRE) begin
        // expired in transit: answer the sender
        via = route_toward(src);
        if (via.action != ipv4rl_pkg::ACT_DROP) begin
          res = via;
          res.action = ipv4rl_pkg::ACT_TIMEX;
          res.msg_type = ipv4rl_pkg::ICMP_TYPE_TIMEX;
          res.msg_code = ipv4rl_pkg::ICMP_CODE_NONE;
        end
      end else begin
        via = route_toward(dst);
        if (via.action != ipv4rl_pkg::ACT_DROP) begin
          res = via;
          res.action = ipv4rl_pkg::ACT_FWD;
          res.ttl_out = ttl - 8'd1;
          res.reply_src_ip = '0;
        end
      end
    end else if (proto == ipv4rl_pkg::PROTO_ICMP) begin
      via = route_toward(src);
      if (echo_ok && via.action != ipv4rl_pkg::ACT_DROP) begin
        res = via;
        res.action = ipv4rl_pkg::ACT_ECHO;
        res.msg_type = ipv4rl_pkg::ICMP_TYPE_ECHO_RP;
        res.msg_code = ipv4rl_pkg::ICMP_CODE_NONE;
      end
    end else if (proto == ipv4rl_pkg::PROTO_TCP || proto == ipv4rl_pkg::PROTO_UDP) begin
      via = route_toward(src);
      if (via.action != ipv4rl_pkg::ACT_DROP) begin
        res = via;
        res.action = ipv4rl_pkg::ACT_PORTUN;
        res.msg_type = ipv4rl_pkg::ICMP_TYPE_UNREACH;
        res.msg_code = ipv4rl_pkg::ICMP_CODE_PORT;
      end
    end
    return res;
  endfunction

  function automatic string show(input ipv4rl_pkg::result_t r);
    return $sformatf("action %0d hop %h iface %0d ttl %0d icmp %0d/%0d reply_src %h",
                     r.action, r.hop_addr, r.out_iface, r.ttl_out, r.msg_type, r.msg_code,
                     r.reply_src_ip);
  endfunction

  always @(posedge clk) begin
    ipv4rl_pkg::result_t seen, want;
    if (!rst_n) begin
      // clear the table and the interface addresses
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
        rt_valid[i] = 1'b0;
        rt_dest[i] = '0;
        rt_mask[i] = '0;
        rt_gw[i] = '0;
        rt_port[i] = '0;
      end
      for (int k = 0; k < ipv4rl_pkg::CFG_REGS; k++) iface_addr[k] = '0;
      decisions_due.delete();
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready &&
          paddr[ipv4rl_pkg::CFG_ADDR_W-1:2] < ipv4rl_pkg::CFG_REGS)
        iface_addr[paddr[ipv4rl_pkg::CFG_ADDR_W-1:2]] = pwdata;

      // predict each accepted word
      if (in_valid && in_ready) begin
        if (in_req_type) begin
          if (int'(in_entry_index) < ROUTE_ENTRIES) begin
            rt_valid[in_entry_index] = in_entry_valid;
            rt_dest[in_entry_index] = in_entry_dest;
            rt_mask[in_entry_index] = in_entry_mask;
            rt_gw[in_entry_index] = in_entry_gateway;
            rt_port[in_entry_index] = in_entry_iface;
          end
          want = '0;
          want.action = ipv4rl_pkg::ACT_WRITE;
        end else begin
          want = forward_decision(in_dst_ip, in_src_ip, in_ttl_in, in_protocol,
                                  in_echo_request_ok);
        end
        decisions_due.push_back(want);
      end

      // compare each result word with the oldest prediction
      if (out_valid && out_ready) begin
        seen.action = ipv4rl_pkg::action_t'(out_action);
        seen.hop_addr = out_hop_addr;
        seen.out_iface = out_out_iface;
        seen.ttl_out = out_ttl_out;
        seen.msg_type = out_msg_type;
        seen.msg_code = out_msg_code;
        seen.reply_src_ip = out_reply_src_ip;
        if (decisions_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("%0t unexpected result word: %s", $time, show(seen));
        end else begin
          want = decisions_due.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
              $display("%0t decision mismatch\n  expected %s\n  actual   %s",
                       $time, show(want), show(seen));
          end
        end
      end
    end
    fails <= mismatches;
    pending <= decisions_due.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 310;
  localparam int IDLE_PCT        = 32;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES    = 2 * ipv4rl_pkg::ROUTE_ENTRIES_DEF + 16;
  localparam int REG_IFACE_IP_0  = 0;
  localparam logic REQ_LOOKUP    = 1'b0;
  localparam logic REQ_WRITE     = 1'b1;
  localparam logic [7:0] PROTO_GRE = 8'd47;

  typedef struct packed {
    logic                               req_type;
    logic [ipv4rl_pkg::ENTRY_IDX_W-1:0] entry_index;
    logic                               entry_valid;
    ipv4rl_pkg::ip_addr_t               entry_dest;
    ipv4rl_pkg::ip_addr_t               entry_mask;
    ipv4rl_pkg::ip_addr_t               entry_gateway;
    logic [1:0]                         entry_iface;
    ipv4rl_pkg::ip_addr_t               dst_ip;
    ipv4rl_pkg::ip_addr_t               src_ip;
    logic [7:0]                         ttl_in;
    logic [7:0]                         protocol;
    logic                               echo_request_ok;
  } route_req_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic                               in_req_type;
  logic [ipv4rl_pkg::ENTRY_IDX_W-1:0] in_entry_index;
  logic                               in_entry_valid;
  logic [31:0]                        in_entry_dest;
  logic [31:0]                        in_entry_mask;
  logic [31:0]                        in_entry_gateway;
  logic [1:0]                         in_entry_iface;
  logic [31:0]                        in_dst_ip;
  logic [31:0]                        in_src_ip;
  logic [7:0]                         in_ttl_in;
  logic [7:0]                         in_protocol;
  logic                               in_echo_request_ok;
  logic                               out_valid;
  logic                               out_ready;
  logic [2:0]                         out_action;
  logic [31:0]                        out_hop_addr;
  logic [1:0]                         out_out_iface;
  logic [7:0]                         out_ttl_out;
  logic [7:0]                         out_msg_type;
  logic [7:0]                         out_msg_code;
  logic [31:0]                        out_reply_src_ip;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [ipv4rl_pkg::CFG_ADDR_W-1:0]  paddr;
  logic [ipv4rl_pkg::CFG_DATA_W-1:0]  pwdata;
  logic [ipv4rl_pkg::CFG_DATA_W-1:0]  prdata;
  logic                               pready;
  int                                 fails;
  int                                 pending;

  // Stimulus side view of the table, used to aim lookup addresses and to copy slots for ties
  ipv4rl_pkg::ip_addr_t   slot_dest [ipv4rl_pkg::ROUTE_ENTRIES_DEF];
  ipv4rl_pkg::ip_addr_t   slot_mask [ipv4rl_pkg::ROUTE_ENTRIES_DEF];
  bit                     slot_used [ipv4rl_pkg::ROUTE_ENTRIES_DEF];
  ipv4rl_pkg::iface_tab_t router_ip;
  bit                     calm;
  bit                     hold_req;

  ipv4_route_lookup_forward_decision dut (.*);
  route_decision_checker chk (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic ipv4rl_pkg::ip_addr_t prefix_mask(input int len);
    return (len == 0) ? 32'h0 : (~32'h0 << (32 - len));
  endfunction

  function automatic route_req_t any_word();
    route_req_t w;
    w.req_type = 1'($urandom_range(1));
    w.entry_index = ipv4rl_pkg::ENTRY_IDX_W'($urandom_range(ipv4rl_pkg::ROUTE_ENTRIES_DEF - 1));
    w.entry_valid = 1'($urandom_range(1));
    w.entry_dest = $urandom;
    w.entry_mask = $urandom;
    w.entry_gateway = $urandom;
    w.entry_iface = 2'($urandom_range(3));
    w.dst_ip = $urandom;
    w.src_ip = $urandom;
    w.ttl_in = 8'($urandom_range(255));
    w.protocol = 8'($urandom_range(255));
    w.echo_request_ok = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic route_req_t slot_write(input int idx, input logic vld,
                                            input ipv4rl_pkg::ip_addr_t dest,
                                            input ipv4rl_pkg::ip_addr_t mask,
                                            input ipv4rl_pkg::ip_addr_t gw,
                                            input logic [1:0] port);
    route_req_t w;
    w = any_word();
    w.req_type = REQ_WRITE;
    w.entry_index = ipv4rl_pkg::ENTRY_IDX_W'(idx);
    w.entry_valid = vld;
    w.entry_dest = dest;
    w.entry_mask = mask;
    w.entry_gateway = gw;
    w.entry_iface = port;
    return w;
  endfunction

  function automatic route_req_t header(input ipv4rl_pkg::ip_addr_t dst,
                                        input ipv4rl_pkg::ip_addr_t src,
                                        input logic [7:0] ttl, input logic [7:0] proto,
                                        input logic ok);
    route_req_t w;
    w = any_word();
    w.req_type = REQ_LOOKUP;
    w.dst_ip = dst;
    w.src_ip = src;
    w.ttl_in = ttl;
    w.protocol = proto;
    w.echo_request_ok = ok;
    return w;
  endfunction

  // Address somewhere inside a written route, random host bits
  function automatic ipv4rl_pkg::ip_addr_t near_route();
    int s;
    s = int'($urandom_range(ipv4rl_pkg::ROUTE_ENTRIES_DEF - 1));
    if (!slot_used[s]) return $urandom;
    return slot_dest[s] | ($urandom & ~slot_mask[s]);
  endfunction

  function automatic ipv4rl_pkg::ip_addr_t pick_addr(input int router_pct);
    int pick;
    pick = int'($urandom_range(99));
    if (pick < router_pct) return router_ip[$urandom_range(ipv4rl_pkg::CFG_REGS - 1)];
    if (pick < router_pct + 55) return near_route();
    return $urandom;
  endfunction

  function automatic route_req_t rand_lookup();
    int         pick;
    logic [7:0] ttl, proto;
    pick = int'($urandom_range(99));
    if (pick < 15) ttl = 8'($urandom_range(1));
    else if (pick < 22) ttl = 8'd2;
    else if (pick < 30) ttl = 8'd255;
    else ttl = 8'($urandom_range(255));
    pick = int'($urandom_range(99));
    if (pick < 35) proto = ipv4rl_pkg::PROTO_ICMP;
    else if (pick < 50) proto = ipv4rl_pkg::PROTO_TCP;
    else if (pick < 65) proto = ipv4rl_pkg::PROTO_UDP;
    else proto = 8'($urandom_range(255));
    return header(pick_addr(30), pick_addr(5), ttl, proto, $urandom_range(99) < 75);
  endfunction

  // Mostly prefix routes; some copy another slot to force ties, some are junk
  function automatic route_req_t rand_write();
    int                   len, s, pick;
    ipv4rl_pkg::ip_addr_t mask, dest;
    pick = int'($urandom_range(99));
    len = (pick < 10) ? 0 : (pick < 20) ? 32 : int'($urandom_range(30, 8));
    mask = prefix_mask(len);
    if ($urandom_range(99) < 8) mask = $urandom;
    dest = $urandom & mask;
    s = int'($urandom_range(ipv4rl_pkg::ROUTE_ENTRIES_DEF - 1));
    pick = int'($urandom_range(99));
    if (pick < 15 && slot_used[s]) begin
      dest = slot_dest[s];
      mask = slot_mask[s];
    end else if (pick >= 93) begin
      dest = $urandom;
    end
    return slot_write(int'($urandom_range(ipv4rl_pkg::ROUTE_ENTRIES_DEF - 1)),
                      $urandom_range(99) < 85, dest, mask,
                      ($urandom_range(99) < 35) ? 32'h0 : 32'($urandom),
                      2'($urandom_range(3)));
  endfunction

  function automatic route_req_t rand_word();
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 3) return any_word();
    if (pick < 21) return rand_write();
    return rand_lookup();
  endfunction

  // Offer one word, with an occasional gap first; hold it until taken
  task automatic send_word(input route_req_t w);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_req_type <= w.req_type;
    in_entry_index <= w.entry_index;
    in_entry_valid <= w.entry_valid;
    in_entry_dest <= w.entry_dest;
    in_entry_mask <= w.entry_mask;
    in_entry_gateway <= w.entry_gateway;
    in_entry_iface <= w.entry_iface;
    in_dst_ip <= w.dst_ip;
    in_src_ip <= w.src_ip;
    in_ttl_in <= w.ttl_in;
    in_protocol <= w.protocol;
    in_echo_request_ok <= w.echo_request_ok;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (w.req_type == REQ_WRITE) begin
      slot_dest[w.entry_index] = w.entry_dest;
      slot_mask[w.entry_index] = w.entry_mask;
      slot_used[w.entry_index] = 1'b1;
    end
  endtask

  task automatic apb_write(input int reg_idx, input ipv4rl_pkg::ip_addr_t data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ipv4rl_pkg::CFG_ADDR_W'(reg_idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_ifaces(input ipv4rl_pkg::iface_tab_t tab);
    for (int k = 0; k < ipv4rl_pkg::CFG_REGS; k++) apb_write(REG_IFACE_IP_0 + k, tab[k]);
    router_ip = tab;
  endtask

  // Drop valid and wait until every decision has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    ipv4rl_pkg::iface_tab_t tab;
    in_valid <= 1'b0;
    in_req_type <= 1'b0;
    in_entry_index <= '0;
    in_entry_valid <= 1'b0;
    in_entry_dest <= '0;
    in_entry_mask <= '0;
    in_entry_gateway <= '0;
    in_entry_iface <= '0;
    in_dst_ip <= '0;
    in_src_ip <= '0;
    in_ttl_in <= '0;
    in_protocol <= '0;
    in_echo_request_ok <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    calm <= 1'b0;
    hold_req <= 1'b0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    tab[0] = 32'h0A00_0001;
    tab[1] = 32'h0A01_0001;
    tab[2] = 32'hC0A8_0101;
    tab[3] = 32'hAC10_0001;
    set_ifaces(tab);

    // Build a small table: default, /16, tied /24 pair, all-ones host, disabled slot
    send_word(slot_write(0, 1'b1, 32'h0, 32'h0, 32'h0A00_00FE, 2'd0));
    send_word(slot_write(3, 1'b1, 32'h0A01_0000, prefix_mask(16), 32'h0, 2'd1));
    send_word(slot_write(5, 1'b1, 32'h0A01_0200, prefix_mask(24), 32'h0A01_02FE, 2'd2));
    send_word(slot_write(9, 1'b1, 32'h0A01_0200, prefix_mask(24), 32'h0A01_02FD, 2'd3));
    send_word(slot_write(15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));
    send_word(slot_write(7, 1'b0, 32'hAC10_0000, prefix_mask(12), 32'h0, 2'd2));
    // Forwarding: tie, zero gateway, default, host route, disabled slot skipped
    send_word(header(32'h0A01_0209, 32'h0A00_0005, 8'd64, ipv4rl_pkg::PROTO_TCP, 1'b0));
    send_word(header(32'h0A01_0909, 32'h0A00_0005, 8'd2, ipv4rl_pkg::PROTO_UDP, 1'b1));
    send_word(header(32'h0808_0808, 32'h0A01_0205, 8'd255, ipv4rl_pkg::PROTO_ICMP, 1'b1));
    send_word(header(32'hFFFF_FFFF, 32'h0, 8'd128, 8'hFF, 1'b1));
    send_word(header(32'hAC10_0505, 32'h0A01_0005, 8'd64, ipv4rl_pkg::PROTO_TCP, 1'b0));
    // TTL expiry at 1 and 0
    send_word(header(32'h0808_0808, 32'h0A01_0005, 8'd1, ipv4rl_pkg::PROTO_ICMP, 1'b0));
    send_word(header(32'h0808_0808, 32'h0A01_0201, 8'd0, ipv4rl_pkg::PROTO_TCP, 1'b1));
    // To the router: echo, bad echo, TCP, UDP, other protocol
    send_word(header(tab[0], 32'h0A01_0203, 8'd64, ipv4rl_pkg::PROTO_ICMP, 1'b1));
    send_word(header(tab[1], 32'h0A01_0203, 8'd64, ipv4rl_pkg::PROTO_ICMP, 1'b0));
    send_word(header(tab[2], 32'h0A01_0707, 8'd1, ipv4rl_pkg::PROTO_TCP, 1'b0));
    send_word(header(tab[3], 32'h0808_0808, 8'd255, ipv4rl_pkg::PROTO_UDP, 1'b1));
    send_word(header(tab[0], 32'h0A01_0203, 8'd64, PROTO_GRE, 1'b1));
    // Remove the default route: every kind of answer loses its route
    send_word(slot_write(0, 1'b0, 32'h0, 32'h0, 32'h0A00_00FE, 2'd0));
    send_word(header(32'h0808_0808, 32'h0A01_0203, 8'd64, ipv4rl_pkg::PROTO_TCP, 1'b0));
    send_word(header(32'h0A01_0203, 32'h0808_0808, 8'd1, ipv4rl_pkg::PROTO_UDP, 1'b0));
    send_word(header(tab[0], 32'h0808_0808, 8'd64, ipv4rl_pkg::PROTO_ICMP, 1'b1));
    send_word(header(tab[2], 32'h0808_0808, 8'd64, ipv4rl_pkg::PROTO_UDP, 1'b1));
    // Default route with no gateway: next hop is the address itself
    send_word(slot_write(0, 1'b1, 32'h0, 32'h0, 32'h0, 2'd1));
    send_word(header(32'h0, 32'hFFFF_FFFF, 8'd2, 8'h00, 1'b0));

    // Random phases, each under its own interface addresses
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        unique case (ph)
          1: tab = '0;
          2: tab = '1;
          3: for (int k = 0; k < ipv4rl_pkg::CFG_REGS; k++) tab[k] = $urandom;
          default: begin
            tab[0] = $urandom;
            tab[1] = tab[0];
            tab[2] = '0;
            tab[3] = 32'hFFFF_FFFF;
          end
        endcase
        settle();
        set_ifaces(tab);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == 100) hold_req <= 1'b1;
        if (ph == 3 && n == 0) calm <= 1'b1;
        if (ph == 3 && n == 160) calm <= 1'b0;
        send_word(rand_word());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
sv/ipv4rl_pkg.sv
sv/ipv4rl_cfg.sv
sv/ipv4rl_front.sv
sv/ipv4rl_fifo.sv
sv/ipv4rl_back.sv
sv/ipv4_route_lookup_forward_decision.sv
tb/sv/route_decision_checker.sv
tb/sv/tb.sv
